// ----- hdl/gffp_pkg.sv -----
// Shared types, register codes and helpers for the grid first-fit placer.
// No dependencies; every other file imports this package.
package gffp_pkg;

  localparam int CNT_W  = 5;
  localparam int Q_W    = 24;
  localparam int GAP_W  = 16;
  localparam int DATA_W = 32;
  localparam int APB_AW = 5;
  localparam int MAG_W  = 25;   // magnitude of content minus total gap
  localparam int PROD_W = 21;   // gap * (count - 1)
  localparam int PITCH_W = 25;  // cell size plus gap
  localparam int MUL_W  = 31;   // span or position times pitch

  localparam logic [2:0] REG_COLUMN_COUNT   = 3'd0;
  localparam logic [2:0] REG_ROW_COUNT      = 3'd1;
  localparam logic [2:0] REG_GAP            = 3'd2;
  localparam logic [2:0] REG_ORIGIN_X       = 3'd3;
  localparam logic [2:0] REG_ORIGIN_Y       = 3'd4;
  localparam logic [2:0] REG_CONTENT_WIDTH  = 3'd5;
  localparam logic [2:0] REG_CONTENT_HEIGHT = 3'd6;

  typedef struct packed {
    logic             start_new_layout;
    logic             item_visible;
    logic [CNT_W-1:0] row_span;
    logic [CNT_W-1:0] col_span;
  } item_t;

  typedef struct packed {
    logic                  placed;
    logic signed [Q_W-1:0] rect_x;
    logic signed [Q_W-1:0] rect_y;
    logic signed [Q_W-1:0] rect_width;
    logic signed [Q_W-1:0] rect_height;
  } result_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic             clear;
    logic             search;
    logic [CNT_W-1:0] row_span;
    logic [CNT_W-1:0] col_span;
    logic [CNT_W-1:0] row_count;
    logic [CNT_W-1:0] col_count;
  } cmd_t;

  // Geometry the back needs to build a rectangle
  typedef struct packed {
    logic signed [Q_W-1:0]     origin_x;
    logic signed [Q_W-1:0]     origin_y;
    logic [GAP_W-1:0]          gap;
    logic signed [PITCH_W-1:0] pitch_w;
    logic signed [PITCH_W-1:0] pitch_h;
  } geom_t;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_LOAD,
    DV_SUB,
    DV_STEP,
    DV_DONE
  } div_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_MARK,
    BK_SUM,
    BK_FINISH
  } back_state_t;

  function automatic logic [CNT_W-1:0] eff_count(logic [CNT_W-1:0] r, int unsigned maxv);
    logic [CNT_W-1:0] n;
    n = r;
    if (r == '0) begin
      n = CNT_W'(1);
    end else if (32'(r) > maxv) begin
      n = CNT_W'(maxv);
    end
    return n;
  endfunction

  function automatic logic signed [Q_W-1:0] sat24(logic signed [31:0] v);
    logic signed [Q_W-1:0] s;
    if (v > 32'sd8388607) begin
      s = 24'sh7FFFFF;
    end else if (v < -32'sd8388608) begin
      s = 24'sh800000;
    end else begin
      s = v[Q_W-1:0];
    end
    return s;
  endfunction

endpackage

// ----- hdl/gffp_ifs.sv -----
// Valid/ready channel interfaces for items and results.
// Depends on gffp_pkg for the payload types.
interface gffp_in_if;
  import gffp_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface gffp_out_if;
  import gffp_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- hdl/gffp_queue.sv -----
// Two-entry command queue between the front and the back.
// Depends on gffp_pkg (cmd_t).
module gffp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gffp_pkg::cmd_t push_cmd,
  input  logic           pop,
  output gffp_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);
  import gffp_pkg::*;

  cmd_t       mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign head  = mem[rp];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- hdl/gffp_front.sv -----
// Front end: takes item beats and classifies them into search or skip commands.
// Depends on gffp_pkg and gffp_ifs.
module gffp_front #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  gffp_in_if.sink                     item,
  input  logic [gffp_pkg::CNT_W-1:0]  column_count,
  input  logic [gffp_pkg::CNT_W-1:0]  row_count,
  input  logic                        cfg_busy,
  input  logic                        q_full,
  output logic                        q_push,
  output gffp_pkg::cmd_t              q_cmd
);
  import gffp_pkg::*;

  logic [CNT_W-1:0] nr;
  logic [CNT_W-1:0] nc;
  logic             fits;

  assign nr = eff_count(row_count, MAX_ROWS);
  assign nc = eff_count(column_count, MAX_COLS);

  // Zero span or a span larger than the grid can never be placed
  assign fits = item.data.item_visible
             && (item.data.row_span != '0) && (item.data.col_span != '0)
             && (item.data.row_span <= nr) && (item.data.col_span <= nc);

  assign item.ready = !cfg_busy && !q_full;
  assign q_push     = item.valid && item.ready;

  always_comb begin
    q_cmd.clear     = item.data.start_new_layout;
    q_cmd.search    = fits;
    q_cmd.row_span  = item.data.row_span;
    q_cmd.col_span  = item.data.col_span;
    q_cmd.row_count = nr;
    q_cmd.col_count = nc;
  end

endmodule

// ----- hdl/gffp_cfg.sv -----
// APB register file plus the cell-size unit (serial restoring divider).
// Depends on gffp_pkg; feeds geometry to the back end.
module gffp_cfg #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gffp_pkg::APB_AW-1:0]  paddr,
  input  logic [gffp_pkg::DATA_W-1:0]  pwdata,
  output logic [gffp_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [gffp_pkg::CNT_W-1:0]   column_count,
  output logic [gffp_pkg::CNT_W-1:0]   row_count,
  output gffp_pkg::geom_t              geom,
  output logic                         busy
);
  import gffp_pkg::*;

  logic [GAP_W-1:0]      gap;
  logic signed [Q_W-1:0] origin_x;
  logic signed [Q_W-1:0] origin_y;
  logic signed [Q_W-1:0] content_width;
  logic signed [Q_W-1:0] content_height;
  logic [2:0]            idx;
  logic                  wr;
  logic                  wr_known;

  div_state_t            state;
  div_state_t            state_next;
  logic                  sel;        // 0: width pass, 1: height pass
  logic [CNT_W-1:0]      n;
  logic [CNT_W-1:0]      n_eff;
  logic [PROD_W-1:0]     prod;
  logic                  neg;
  logic [MAG_W-1:0]      mag;
  logic [CNT_W-1:0]      rem;
  logic [CNT_W-1:0]      cnt;
  logic signed [Q_W-1:0] content_sel;
  logic signed [MAG_W:0] avail;
  logic [CNT_W:0]        rem_sh;
  logic                  ge;
  logic signed [31:0]    quot;
  logic signed [Q_W-1:0] cell_q;
  logic signed [PITCH_W-1:0] pitch;
  logic signed [PITCH_W-1:0] pitch_w;
  logic signed [PITCH_W-1:0] pitch_h;

  assign pready   = 1'b1;
  assign idx      = paddr[APB_AW-1:2];
  assign wr       = psel && penable && pwrite;
  assign wr_known = wr && (idx <= REG_CONTENT_HEIGHT);

  always_comb begin
    case (idx)
      REG_COLUMN_COUNT:   prdata = DATA_W'(column_count);
      REG_ROW_COUNT:      prdata = DATA_W'(row_count);
      REG_GAP:            prdata = DATA_W'(gap);
      REG_ORIGIN_X:       prdata = {8'd0, origin_x};
      REG_ORIGIN_Y:       prdata = {8'd0, origin_y};
      REG_CONTENT_WIDTH:  prdata = {8'd0, content_width};
      REG_CONTENT_HEIGHT: prdata = {8'd0, content_height};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count   <= CNT_W'(1);
      row_count      <= CNT_W'(1);
      gap            <= '0;
      origin_x       <= '0;
      origin_y       <= '0;
      content_width  <= '0;
      content_height <= '0;
    end else if (wr) begin
      case (idx)
        REG_COLUMN_COUNT:   column_count   <= pwdata[CNT_W-1:0];
        REG_ROW_COUNT:      row_count      <= pwdata[CNT_W-1:0];
        REG_GAP:            gap            <= pwdata[GAP_W-1:0];
        REG_ORIGIN_X:       origin_x       <= pwdata[Q_W-1:0];
        REG_ORIGIN_Y:       origin_y       <= pwdata[Q_W-1:0];
        REG_CONTENT_WIDTH:  content_width  <= pwdata[Q_W-1:0];
        REG_CONTENT_HEIGHT: content_height <= pwdata[Q_W-1:0];
        default: ;
      endcase
    end
  end

  // Cell size: (content - gap*(n-1)) / n, truncated toward zero, done as
  // magnitude division one quotient bit per cycle, width pass then height.
  assign n_eff = sel ? eff_count(row_count, MAX_ROWS) : eff_count(column_count, MAX_COLS);
  assign content_sel = sel ? content_height : content_width;
  assign avail  = {{2{content_sel[Q_W-1]}}, content_sel} - $signed({5'd0, prod});
  assign rem_sh = {rem, mag[MAG_W-1]};
  assign ge     = (rem_sh >= {1'b0, n});
  assign quot   = neg ? -$signed({7'd0, mag}) : $signed({7'd0, mag});
  assign cell_q = sat24(quot);
  assign pitch  = $signed({cell_q[Q_W-1], cell_q}) + $signed({9'd0, gap});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      DV_IDLE: state_next = DV_IDLE;
      DV_LOAD: state_next = DV_SUB;
      DV_SUB:  state_next = DV_STEP;
      DV_STEP: begin
        if (cnt == CNT_W'(MAG_W - 1)) begin
          state_next = DV_DONE;
        end
      end
      DV_DONE: state_next = sel ? DV_IDLE : DV_LOAD;
      default: state_next = DV_IDLE;
    endcase
    if (wr_known) begin
      state_next = DV_LOAD;
    end
  end

  assign busy = (state != DV_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      sel     <= 1'b0;
      pitch_w <= '0;
      pitch_h <= '0;
    end else if (wr_known) begin
      sel <= 1'b0;
    end else if (state == DV_DONE) begin
      sel <= 1'b1;
      if (sel) begin
        pitch_h <= pitch;
      end else begin
        pitch_w <= pitch;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      DV_LOAD: begin
        n    <= n_eff;
        prod <= PROD_W'(gap) * PROD_W'(n_eff - CNT_W'(1));
      end
      DV_SUB: begin
        neg <= avail[MAG_W];
        mag <= avail[MAG_W] ? MAG_W'(-avail) : avail[MAG_W-1:0];
        rem <= '0;
        cnt <= '0;
      end
      DV_STEP: begin
        rem <= ge ? CNT_W'(rem_sh - {1'b0, n}) : rem_sh[CNT_W-1:0];
        mag <= {mag[MAG_W-2:0], ge};
        cnt <= cnt + CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    geom.origin_x = origin_x;
    geom.origin_y = origin_y;
    geom.gap      = gap;
    geom.pitch_w  = pitch_w;
    geom.pitch_h  = pitch_h;
  end

endmodule

// ----- hdl/gffp_back.sv -----
// Back end: occupancy bitmap, one start row tested per cycle, marking and
// rectangle arithmetic, plus the result output register.
// Depends on gffp_pkg and gffp_ifs.
module gffp_back #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  gffp_pkg::cmd_t  cmd,
  input  logic            q_empty,
  output logic            q_pop,
  input  gffp_pkg::geom_t geom,
  gffp_out_if.source      result
);
  import gffp_pkg::*;

  logic [MAX_COLS-1:0] bitmap [MAX_ROWS];

  back_state_t         state;
  back_state_t         state_next;
  cmd_t                cur;
  logic [CNT_W-1:0]    r;
  logic [CNT_W-1:0]    fc;
  logic [CNT_W-1:0]    first_c;
  logic [CNT_W:0]      win_end;
  logic                last_row;
  logic [MAX_ROWS-1:0] in_win;
  logic [MAX_COLS-1:0] win;
  logic [MAX_COLS-1:0] span;
  logic [MAX_COLS-1:0] fit;
  logic                found;
  logic [MAX_COLS-1:0] mark_mask;
  logic signed [MUL_W-1:0] px;
  logic signed [MUL_W-1:0] py;
  logic signed [MUL_W-1:0] pw;
  logic signed [MUL_W-1:0] ph;
  logic signed [31:0]  gap_s;
  result_t             res;
  logic                out_valid;
  result_t             out_data;
  logic                out_load;

  assign win_end  = {1'b0, r} + {1'b0, cur.row_span};
  assign last_row = (win_end >= {1'b0, cur.row_count});
  assign span     = ~({MAX_COLS{1'b1}} << cur.col_span);
  assign mark_mask = span << fc;
  assign gap_s    = $signed({16'd0, geom.gap});

  // OR of the rows covered by the start row under test
  always_comb begin
    win = '0;
    for (int k = 0; k < MAX_ROWS; k++) begin
      in_win[k] = (7'(k) >= {2'b0, r}) && (7'(k) < {1'b0, win_end});
      if (in_win[k]) begin
        win = win | bitmap[k];
      end
    end
  end

  always_comb begin
    first_c = '0;
    for (int c = 0; c < MAX_COLS; c++) begin
      fit[c] = (c + int'(cur.col_span) <= int'(cur.col_count))
            && ((win & (span << c)) == '0);
    end
    for (int c = MAX_COLS - 1; c >= 0; c--) begin
      if (fit[c]) begin
        first_c = CNT_W'(c);
      end
    end
  end

  assign found = (fit != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = cmd.search ? BK_SEARCH : BK_FINISH;
        end
      end
      BK_SEARCH: begin
        if (found) begin
          state_next = BK_MARK;
        end else if (last_row) begin
          state_next = BK_FINISH;
        end
      end
      BK_MARK: state_next = BK_SUM;
      BK_SUM:  state_next = BK_FINISH;
      BK_FINISH: begin
        if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Bitmap: cleared at once on a new layout, marked in the cycle after a hit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_ROWS; k++) begin
        bitmap[k] <= '0;
      end
    end else if (q_pop && cmd.clear) begin
      for (int k = 0; k < MAX_ROWS; k++) begin
        bitmap[k] <= '0;
      end
    end else if (state == BK_MARK) begin
      for (int k = 0; k < MAX_ROWS; k++) begin
        if (in_win[k]) begin
          bitmap[k] <= bitmap[k] | mark_mask;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          cur <= cmd;
          r   <= '0;
          res <= '0;
        end
      end
      BK_SEARCH: begin
        if (found) begin
          fc <= first_c;
        end else begin
          r <= r + CNT_W'(1);
        end
      end
      BK_MARK: begin
        px <= $signed({1'b0, fc}) * geom.pitch_w;
        py <= $signed({1'b0, r}) * geom.pitch_h;
        pw <= $signed({1'b0, cur.col_span}) * geom.pitch_w;
        ph <= $signed({1'b0, cur.row_span}) * geom.pitch_h;
      end
      BK_SUM: begin
        res.placed      <= 1'b1;
        res.rect_x      <= sat24(32'(geom.origin_x) + 32'(px));
        res.rect_y      <= sat24(32'(geom.origin_y) + 32'(py));
        res.rect_width  <= sat24(32'(pw) - gap_s);
        res.rect_height <= sat24(32'(ph) - gap_s);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule

// ----- hdl/grid_first_fit_placer.sv -----
// Channel   Dir  Beat payload                                   Handshake
// item      in   start_new_layout, item_visible, spans          valid/ready
// result    out  placed, rect_x, rect_y, rect_width, rect_height valid/ready
// apb       in   column_count .. content_height, 32-bit words   psel/penable
//
// In the back end a placed item goes from idle through search, mark and sum
// to finish, trying S start rows (1 .. row_count - row_span + 1); one that
// fits nowhere goes from search to finish, and skipped items from idle to
// finish. The row scan is the limit: one start row per cycle, all columns
// tested in parallel. A register write recomputes both cell sizes in a
// serial divider, during which item.ready is low. Reset (rst, synchronous)
// empties the grid. A two-entry queue lets the front take beats while the
// back scans or the result register waits on result.ready.
module grid_first_fit_placer #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  gffp_in_if.sink                      item,
  gffp_out_if.source                   result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gffp_pkg::APB_AW-1:0]  paddr,
  input  logic [gffp_pkg::DATA_W-1:0]  pwdata,
  output logic [gffp_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import gffp_pkg::*;

  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;
  geom_t            geom;
  logic             cfg_busy;
  logic             q_push;
  logic             q_pop;
  logic             q_empty;
  logic             q_full;
  cmd_t             q_cmd;
  cmd_t             q_head;

  gffp_cfg #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .column_count (column_count),
    .row_count    (row_count),
    .geom         (geom),
    .busy         (cfg_busy)
  );

  gffp_front #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_front (
    .item         (item),
    .column_count (column_count),
    .row_count    (row_count),
    .cfg_busy     (cfg_busy),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  gffp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  gffp_back #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cmd     (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .geom    (geom),
    .result  (result)
  );

  a_no_item_while_div: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |-> !cfg_busy)
    else $error("item taken while cell size unit busy");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("back end popped an empty queue");

  a_unplaced_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.data.placed) |->
      (result.data.rect_x == '0) && (result.data.rect_y == '0) &&
      (result.data.rect_width == '0) && (result.data.rect_height == '0))
    else $error("unplaced result carries a nonzero rectangle");

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for grid_first_fit_placer: a directed table of placements,
// then random layouts under changing grid setups, each result beat checked.
// Depends on gffp_pkg, the gffp_in_if / gffp_out_if interfaces and the placer RTL.
module tb;
  import gffp_pkg::*;

  localparam int GRID_ROWS     = 16;
  localparam int GRID_COLS     = 16;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 158;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  reg_idx;
    logic [31:0] value;
    item_t       it;
    bit          typed;
    result_t     want;
  } plan_row_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic              pready;
  logic [APB_AW-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;

  gffp_in_if  item_ch();
  gffp_out_if res_ch();

  grid_first_fit_placer #(
    .MAX_ROWS(GRID_ROWS),
    .MAX_COLS(GRID_COLS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // placement model state: registers, derived cell sizes, occupancy
  logic [CNT_W-1:0]      m_cols   = 5'd1;
  logic [CNT_W-1:0]      m_rows   = 5'd1;
  logic [GAP_W-1:0]      m_gap    = '0;
  logic signed [Q_W-1:0] m_org_x  = '0;
  logic signed [Q_W-1:0] m_org_y  = '0;
  logic signed [Q_W-1:0] m_cont_w = '0;
  logic signed [Q_W-1:0] m_cont_h = '0;
  logic signed [Q_W-1:0] m_cell_w = '0;
  logic signed [Q_W-1:0] m_cell_h = '0;
  logic [GRID_COLS-1:0]  grid_occ [GRID_ROWS] = '{default: '0};

  result_t pending_rects[$];
  int      send_idle_pct = 29;
  int      recv_idle_pct = 76;
  int      hold_request  = 0;
  int      err_count     = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int grid_dim(logic [CNT_W-1:0] r, int maxv);
    int n;
    n = int'(r);
    if (n < 1) n = 1;
    if (n > maxv) n = maxv;
    return n;
  endfunction

  function automatic logic signed [Q_W-1:0] clip_q24(longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[Q_W-1:0];
  endfunction

  // truncating divide of what is left after the gaps
  function automatic logic signed [Q_W-1:0] cell_span(logic signed [Q_W-1:0] content, int n);
    longint avail;
    avail = longint'(content) - longint'(m_gap) * (n - 1);
    return clip_q24(avail / n);
  endfunction

  function automatic result_t place_item(item_t it);
    result_t     res;
    int          nr;
    int          nc;
    int          rs;
    int          cs;
    int          fr;
    int          fc;
    bit          found;
    logic [31:0] m;
    longint      g;
    nr = grid_dim(m_rows, GRID_ROWS);
    nc = grid_dim(m_cols, GRID_COLS);
    rs = int'(it.row_span);
    cs = int'(it.col_span);
    g = longint'(m_gap);
    res = '0;
    found = 1'b0;
    fr = 0;
    fc = 0;
    if (it.start_new_layout) foreach (grid_occ[k]) grid_occ[k] = '0;
    if (!it.item_visible || rs < 1 || cs < 1 || rs > nr || cs > nc) return res;
    // row-major first fit
    for (int r = 0; r + rs <= nr && !found; r++) begin
      for (int c = 0; c + cs <= nc && !found; c++) begin
        m = ((32'd1 << cs) - 32'd1) << c;
        found = 1'b1;
        for (int k = r; k < r + rs; k++) begin
          if ((grid_occ[k] & m[GRID_COLS-1:0]) != '0) found = 1'b0;
        end
        if (found) begin
          fr = r;
          fc = c;
        end
      end
    end
    if (!found) return res;
    m = ((32'd1 << cs) - 32'd1) << fc;
    for (int k = fr; k < fr + rs; k++) grid_occ[k] |= m[GRID_COLS-1:0];
    res.placed      = 1'b1;
    res.rect_x      = clip_q24(longint'(m_org_x) + fc * (longint'(m_cell_w) + g));
    res.rect_y      = clip_q24(longint'(m_org_y) + fr * (longint'(m_cell_h) + g));
    res.rect_width  = clip_q24(cs * longint'(m_cell_w) + (cs - 1) * g);
    res.rect_height = clip_q24(rs * longint'(m_cell_h) + (rs - 1) * g);
    return res;
  endfunction

  function automatic plan_row_t item_row(bit snl, bit vis, int rs, int cs, int placed_typed);
    plan_row_t r;
    r.is_cfg  = 1'b0;
    r.reg_idx = REG_COLUMN_COUNT;
    r.value   = '0;
    r.it.start_new_layout = snl;
    r.it.item_visible     = vis;
    r.it.row_span         = 5'(rs);
    r.it.col_span         = 5'(cs);
    r.typed       = (placed_typed >= 0);
    r.want        = '0;
    r.want.placed = (placed_typed == 1);
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [2:0] idx, logic [31:0] val);
    plan_row_t r;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.value   = val;
    r.it      = '0;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic logic [31:0] pick_count();
    if ($urandom_range(99) < 15) return 32'($urandom_range(31));
    return 32'($urandom_range(GRID_COLS, 1));
  endfunction

  function automatic logic [31:0] pick_content();
    case ($urandom_range(9))
      0: return 32'h007F_FFFF;
      1: return 32'h0080_0000;
      2, 3: return {8'h00, 24'($urandom)};
      default: return 32'($urandom_range(32'h2_0000));
    endcase
  endfunction

  function automatic logic [31:0] pick_origin();
    if ($urandom_range(3) == 0) return {8'h00, 24'($urandom)};
    return {8'h00, 24'($urandom_range(4096)) - 24'd2048};
  endfunction

  function automatic logic [31:0] pick_gap();
    case ($urandom_range(9))
      0: return 32'h0000_FFFF;
      1: return 32'h0;
      2, 3: return 32'($urandom_range(32'hFFFF));
      default: return 32'($urandom_range(32'h300));
    endcase
  endfunction

  task automatic match_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  task automatic send_item(item_t it, bit typed, result_t want);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    predicted = place_item(it);
    pending_rects = {pending_rects, (typed ? want : predicted)};
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    while (pending_rects.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // psel stays high across back-to-back writes; cfg_release drops it
  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_COLUMN_COUNT:   m_cols   = val[CNT_W-1:0];
      REG_ROW_COUNT:      m_rows   = val[CNT_W-1:0];
      REG_GAP:            m_gap    = val[GAP_W-1:0];
      REG_ORIGIN_X:       m_org_x  = val[Q_W-1:0];
      REG_ORIGIN_Y:       m_org_y  = val[Q_W-1:0];
      REG_CONTENT_WIDTH:  m_cont_w = val[Q_W-1:0];
      REG_CONTENT_HEIGHT: m_cont_h = val[Q_W-1:0];
      default: ;
    endcase
    m_cell_w = cell_span(m_cont_w, grid_dim(m_cols, GRID_COLS));
    m_cell_h = cell_span(m_cont_h, grid_dim(m_rows, GRID_ROWS));
  endtask

  task automatic cfg_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // result side: random ready, long hold-offs on request, in-order checking
  initial begin
    int      hold_left;
    result_t got;
    result_t want;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        got = res_ch.data;
        if (pending_rects.size() == 0) begin
          $error("result beat with nothing expected: placed=%0b rect_x=%0d",
                 got.placed, got.rect_x);
          err_count++;
        end else begin
          want = pending_rects.pop_front();
          match_field("placed", want.placed, got.placed);
          match_field("rect_x", want.rect_x, got.rect_x);
          match_field("rect_y", want.rect_y, got.rect_y);
          match_field("rect_width", want.rect_width, got.rect_width);
          match_field("rect_height", want.rect_height, got.rect_height);
        end
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    plan_row_t plan[$];
    item_t     it;
    int        seg_left;
    int        nr;
    int        nc;
    int        cap_r;
    int        cap_c;
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    item_ch.valid <= 1'b0;
    item_ch.data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // after reset the grid is one cell of zero size at the origin
    plan = {plan, item_row(0, 1, 1, 1, 1)};
    plan = {plan, item_row(0, 1, 1, 1, 0)};     // grid full
    plan = {plan, item_row(1, 0, 1, 1, 0)};     // hidden, still clears
    plan = {plan, item_row(0, 1, 1, 1, 1)};
    plan = {plan, item_row(1, 1, 0, 0, 0)};     // zero span
    plan = {plan, item_row(1, 1, 31, 31, 0)};   // larger than grid
    plan = {plan, item_row(0, 1, 1, 0, 0)};
    // zero columns acts as one, 31 rows as the maximum
    plan = {plan, cfg_row(REG_COLUMN_COUNT, 32'd0)};
    plan = {plan, cfg_row(REG_ROW_COUNT, 32'd31)};
    plan = {plan, cfg_row(REG_GAP, 32'h100)};
    plan = {plan, cfg_row(REG_CONTENT_WIDTH, 32'h1000)};
    plan = {plan, cfg_row(REG_CONTENT_HEIGHT, 32'h2000)};
    plan = {plan, item_row(1, 1, 16, 1, -1)};
    plan = {plan, item_row(0, 1, 1, 1, -1)};
    plan = {plan, item_row(0, 1, 17, 1, -1)};
    plan = {plan, item_row(1, 1, 3, 2, -1)};
    // 4x4 grid, negative origin x
    plan = {plan, cfg_row(REG_COLUMN_COUNT, 32'd4)};
    plan = {plan, cfg_row(REG_ROW_COUNT, 32'd4)};
    plan = {plan, cfg_row(REG_GAP, 32'h80)};
    plan = {plan, cfg_row(REG_ORIGIN_X, 32'hFF_FF00)};
    plan = {plan, cfg_row(REG_ORIGIN_Y, 32'h300)};
    plan = {plan, cfg_row(REG_CONTENT_WIDTH, 32'h4000)};
    plan = {plan, cfg_row(REG_CONTENT_HEIGHT, 32'h3000)};
    plan = {plan, item_row(1, 1, 2, 2, -1)};
    plan = {plan, item_row(0, 1, 1, 3, -1)};
    plan = {plan, item_row(0, 1, 3, 1, -1)};
    plan = {plan, item_row(0, 1, 2, 2, -1)};
    plan = {plan, item_row(0, 1, 4, 4, -1)};
    // widen mid layout, occupancy kept
    plan = {plan, cfg_row(REG_COLUMN_COUNT, 32'd8)};
    plan = {plan, item_row(0, 1, 1, 4, -1)};
    plan = {plan, item_row(0, 1, 4, 5, -1)};
    plan = {plan, item_row(0, 1, 2, 3, -1)};
    // extremes, rectangles saturate
    plan = {plan, cfg_row(REG_COLUMN_COUNT, 32'd20)};
    plan = {plan, cfg_row(REG_ROW_COUNT, 32'd16)};
    plan = {plan, cfg_row(REG_GAP, 32'hFFFF)};
    plan = {plan, cfg_row(REG_ORIGIN_X, 32'h7F_FFFF)};
    plan = {plan, cfg_row(REG_ORIGIN_Y, 32'h80_0000)};
    plan = {plan, cfg_row(REG_CONTENT_WIDTH, 32'h7F_FFFF)};
    plan = {plan, cfg_row(REG_CONTENT_HEIGHT, 32'h80_0000)};
    plan = {plan, item_row(1, 1, 1, 1, -1)};
    plan = {plan, item_row(0, 1, 16, 15, -1)};
    plan = {plan, item_row(0, 1, 1, 1, -1)};
    plan = {plan, item_row(1, 1, 16, 16, -1)};

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_drained();
        cfg_write(plan[i].reg_idx, plan[i].value);
        cfg_release();
      end else begin
        send_item(plan[i].it, plan[i].typed, plan[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p < 4) begin
        send_idle_pct = 29;
        recv_idle_pct = 76;
      end else if (p < 8) begin
        send_idle_pct = 76;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_drained();
      cfg_write(REG_COLUMN_COUNT, pick_count());
      cfg_write(REG_ROW_COUNT, pick_count());
      cfg_write(REG_GAP, pick_gap());
      cfg_write(REG_ORIGIN_X, pick_origin());
      cfg_write(REG_ORIGIN_Y, pick_origin());
      cfg_write(REG_CONTENT_WIDTH, pick_content());
      cfg_write(REG_CONTENT_HEIGHT, pick_content());
      cfg_release();
      seg_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // stall the result side long enough to back up the input
        if (n == 30 && (p == 1 || p == 9)) hold_request = 400;
        if (n == 80 && p == 5) wait_drained();
        nr = grid_dim(m_rows, GRID_ROWS);
        nc = grid_dim(m_cols, GRID_COLS);
        if ($urandom_range(99) < 12) begin
          it = item_t'(12'($urandom));
        end else begin
          // layouts: a clearing beat, then a run of mostly small spans
          it = '0;
          it.start_new_layout = (seg_left == 0);
          if (seg_left == 0) seg_left = $urandom_range(24, 3);
          seg_left--;
          it.item_visible = ($urandom_range(99) >= 6);
          cap_r = ($urandom_range(3) == 0) ? nr : ((nr < 4) ? nr : 4);
          cap_c = ($urandom_range(3) == 0) ? nc : ((nc < 4) ? nc : 4);
          it.row_span = 5'($urandom_range(cap_r, 1));
          it.col_span = 5'($urandom_range(cap_c, 1));
        end
        send_item(it, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
